// ===== design/utf8bs_pkg.sv =====
// shared types and constants for the utf-8 byte sanitizer
`default_nettype none

package utf8bs_pkg;

   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned HELD_DEPTH  = 3;
   localparam int unsigned COUNT_W     = $clog2(MAX_RESULTS + 1);
   localparam int unsigned SLOT_W      = $clog2(MAX_RESULTS);

   localparam logic [7:0] REPL_CHAR   = 8'd63;
   localparam logic [1:0] CONT_TAG    = 2'b10;
   localparam logic [2:0] LEAD2_TAG   = 3'b110;
   localparam logic [3:0] LEAD3_TAG   = 4'b1110;
   localparam logic [4:0] LEAD4_TAG   = 5'b11110;

   typedef struct packed {
      logic [7:0] data;
      logic       replaced;
   } result_type;

   typedef struct packed {
      logic                                load;
      logic                                stream_end;
      logic [COUNT_W-1:0]                  count;
      result_type [MAX_RESULTS-1:0]        slots;
   } burst_load_type;

endpackage

`default_nettype wire

// ===== design/utf8bs_step.sv =====
// sequence state and per-byte repair logic for the utf-8 byte sanitizer
`default_nettype none

module utf8bs_step (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic [7:0]             in_byte,
   input  wire logic                   stream_end,
   output utf8bs_pkg::burst_load_type  burst_load
);

   logic [7:0] held_ff [utf8bs_pkg::HELD_DEPTH];
   logic [7:0] held_in [utf8bs_pkg::HELD_DEPTH];
   logic [1:0] held_count_ff;
   logic [1:0] held_count_in;
   logic [1:0] need_ff;
   logic [1:0] need_in;

   always_comb begin
      logic [1:0]                                    hc;
      logic [1:0]                                    need;
      logic [utf8bs_pkg::COUNT_W-1:0]                n;
      logic                                          fresh;
      utf8bs_pkg::result_type [utf8bs_pkg::MAX_RESULTS-1:0] slots;

      hc    = held_count_ff;
      need  = need_ff;
      n     = '0;
      fresh = 1'b0;
      slots = '0;
      held_in = held_ff;

      if (need != 2'd0) begin
         if (in_byte[7:6] == utf8bs_pkg::CONT_TAG) begin
            need = need - 2'd1;
            if (need == 2'd0) begin
               for (int k = 0; k < utf8bs_pkg::HELD_DEPTH; k++) begin
                  if (2'(k) < hc) begin
                     slots[n[utf8bs_pkg::SLOT_W-1:0]] = '{data: held_ff[k], replaced: 1'b0};
                     n = n + 1'b1;
                  end
               end
               slots[n[utf8bs_pkg::SLOT_W-1:0]] = '{data: in_byte, replaced: 1'b0};
               n  = n + 1'b1;
               hc = 2'd0;
            end else if (hc != 2'd3) begin
               held_in[hc] = in_byte;
               hc = hc + 2'd1;
            end
         end else begin
            // broken sequence
            for (int k = 0; k < utf8bs_pkg::HELD_DEPTH; k++) begin
               if (2'(k) < hc) begin
                  slots[n[utf8bs_pkg::SLOT_W-1:0]] =
                     '{data: utf8bs_pkg::REPL_CHAR, replaced: 1'b1};
                  n = n + 1'b1;
               end
            end
            hc    = 2'd0;
            need  = 2'd0;
            fresh = 1'b1;
         end
      end else begin
         fresh = 1'b1;
      end

      if (fresh) begin
         if (!in_byte[7]) begin
            slots[n[utf8bs_pkg::SLOT_W-1:0]] = '{data: in_byte, replaced: 1'b0};
            n = n + 1'b1;
         end else if (in_byte[7:5] == utf8bs_pkg::LEAD2_TAG) begin
            held_in[0] = in_byte;
            hc   = 2'd1;
            need = 2'd1;
         end else if (in_byte[7:4] == utf8bs_pkg::LEAD3_TAG) begin
            held_in[0] = in_byte;
            hc   = 2'd1;
            need = 2'd2;
         end else if (in_byte[7:3] == utf8bs_pkg::LEAD4_TAG) begin
            held_in[0] = in_byte;
            hc   = 2'd1;
            need = 2'd3;
         end else begin
            slots[n[utf8bs_pkg::SLOT_W-1:0]] =
               '{data: utf8bs_pkg::REPL_CHAR, replaced: 1'b1};
            n = n + 1'b1;
         end
      end

      // early end of stream
      if (stream_end && (need != 2'd0)) begin
         for (int k = 0; k < utf8bs_pkg::HELD_DEPTH; k++) begin
            if (2'(k) < hc) begin
               slots[n[utf8bs_pkg::SLOT_W-1:0]] =
                  '{data: utf8bs_pkg::REPL_CHAR, replaced: 1'b1};
               n = n + 1'b1;
            end
         end
         hc   = 2'd0;
         need = 2'd0;
      end

      held_count_in         = hc;
      need_in               = need;
      burst_load.load       = advance;
      burst_load.stream_end = stream_end;
      burst_load.count      = n;
      burst_load.slots      = slots;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         need_ff       <= 2'd0;
      end else if (advance) begin
         held_count_ff <= held_count_in;
         need_ff       <= need_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/utf8bs_burst.sv =====
// output buffer that drains the results of one byte, one per cycle while rsp_ready is high
`default_nettype none

module utf8bs_burst (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire utf8bs_pkg::burst_load_type burst_load,
   output logic                            can_load,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_replaced,
   output logic                            rsp_run_last,
   output logic                            rsp_stream_done
);

   localparam int unsigned N = utf8bs_pkg::MAX_RESULTS;

   logic [7:0]                     data_ff [N];
   logic [7:0]                     data_in [N];
   logic [N-1:0]                   rep_ff;
   logic [N-1:0]                   rep_in;
   logic [N-1:0]                   last_ff;
   logic [N-1:0]                   last_in;
   logic [N-1:0]                   done_ff;
   logic [N-1:0]                   done_in;
   logic [utf8bs_pkg::COUNT_W-1:0] count_ff;
   logic [utf8bs_pkg::COUNT_W-1:0] count_in;
   logic                           pop;

   assign pop      = (count_ff != '0) && rsp_ready;
   assign can_load = (count_ff == '0) ||
                     ((count_ff == utf8bs_pkg::COUNT_W'(1)) && pop);

   always_comb begin
      data_in  = data_ff;
      rep_in   = rep_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      count_in = count_ff;
      if (burst_load.load && can_load) begin
         for (int i = 0; i < N; i++) begin
            data_in[i] = burst_load.slots[i].data;
            rep_in[i]  = burst_load.slots[i].replaced;
            last_in[i] = (utf8bs_pkg::COUNT_W'(i + 1) == burst_load.count);
            done_in[i] = last_in[i] && burst_load.stream_end;
         end
         count_in = burst_load.count;
      end else if (pop) begin
         for (int i = 0; i < N - 1; i++) begin
            data_in[i] = data_ff[i + 1];
            rep_in[i]  = rep_ff[i + 1];
            last_in[i] = last_ff[i + 1];
            done_in[i] = done_ff[i + 1];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rep_ff  <= rep_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_valid       = (count_ff != '0);
   assign rsp_out_byte    = data_ff[0];
   assign rsp_replaced    = rep_ff[0];
   assign rsp_run_last    = last_ff[0];
   assign rsp_stream_done = done_ff[0];

endmodule

`default_nettype wire

// ===== design/utf8_byte_sanitizer.sv =====
// top level of the utf-8 byte sanitizer
//
// Passes a byte stream through and repairs invalid UTF-8: complete sequences
// come out unchanged, bad leads, stray continuations and broken or unfinished
// sequences come out as '?' with rsp_replaced set. An accepted byte waits in
// the input register until the four-entry output buffer can take its 0 to 4
// result items. The buffer drains one item per cycle on the single result
// port while rsp_ready is high and takes the next byte's results only once
// empty or as its last item leaves, so a byte is accepted every cycle while
// each byte yields at most one result and rsp_ready is high, and a byte that
// yields several results stalls the input until all but its last have left.
// Lead bytes and held continuations yield no result until the sequence ends.
`default_nettype none

module utf8_byte_sanitizer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_stream_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_replaced,
   output logic            rsp_run_last,
   output logic            rsp_stream_done
);

   logic                       in_valid_ff;
   logic                       in_valid_in;
   logic [7:0]                 in_byte_ff;
   logic                       in_end_ff;
   logic                       can_load;
   logic                       advance;
   logic                       req_fire;
   utf8bs_pkg::burst_load_type burst_load;

   assign advance   = in_valid_ff && can_load;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_in_byte;
         in_end_ff  <= req_stream_end;
      end
   end

   utf8bs_step u_step (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_byte    (in_byte_ff),
      .stream_end (in_end_ff),
      .burst_load (burst_load)
   );

   utf8bs_burst u_burst (
      .clock           (clock),
      .reset           (reset),
      .burst_load      (burst_load),
      .can_load        (can_load),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_replaced    (rsp_replaced),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_done (rsp_stream_done)
   );

endmodule

`default_nettype wire

// ===== design/utf8bs_checker.sv =====
// port-level assertions for the utf-8 byte sanitizer and their bind
`default_nettype none

module utf8bs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_replaced,
   input wire logic       rsp_run_last,
   input wire logic       rsp_stream_done
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_replaced) && $stable(rsp_run_last) && $stable(rsp_stream_done))
      else $error("result item changed while stalled");

   a_repl_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_replaced |-> rsp_out_byte == utf8bs_pkg::REPL_CHAR)
      else $error("replaced item is not the replacement character");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |-> rsp_run_last)
      else $error("end of stream marked on an item that is not the last of its run");

   a_no_bad_lead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_replaced |-> rsp_out_byte[7:3] != 5'b11111)
      else $error("invalid lead byte passed unreplaced");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind utf8_byte_sanitizer utf8bs_checker u_utf8bs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_replaced    (rsp_replaced),
   .rsp_run_last    (rsp_run_last),
   .rsp_stream_done (rsp_stream_done)
);

`default_nettype wire
